// File: rtl/amdf_pkg.sv
// ----------------------------------------------------------------------------
// amdf_pkg
// Shared constants and types for the axis median deadband filter.
// ----------------------------------------------------------------------------
package amdf_pkg;

   localparam int NUM_AXES = 8;
   localparam int WINDOW   = 5;

   localparam int AXIS_W   = 3;
   localparam int SAMPLE_W = 16;
   localparam int MARGIN_W = 8;
   localparam int ACTIVE_W = 4;
   localparam int CSR_IW   = 2;
   localparam int CSR_DW   = 8;

   localparam int ADDR_W   = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
   localparam int CNT_W    = $clog2(WINDOW + 1);
   localparam int RANK_W   = $clog2(WINDOW);
   // Row layout: held value on top of the window slots, slot 0 at the bottom.
   localparam int ROW_W    = SAMPLE_W * (WINDOW + 1);
   localparam int MED_RANK = WINDOW / 2;

   localparam logic [MARGIN_W-1:0] NOISE_MARGIN_RST = MARGIN_W'(2);
   localparam logic [ACTIVE_W-1:0] ACTIVE_AXES_RST  = ACTIVE_W'(8);

   typedef enum logic [CSR_IW-1:0] {
      CSR_NOISE_MARGIN = 2'd0,
      CSR_ACTIVE_AXES  = 2'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMP,
      ST_MED,
      ST_WB
   } state_type;

endpackage

// File: rtl/axis_median_deadband_filter_top.sv
// ----------------------------------------------------------------------------
// axis_median_deadband_filter_top
// Per-axis sliding-window median filter with a deadband on the held value.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | req_axis_index, req_sample_value
//   rsp     | out       | rsp_valid/rsp_stall | rsp_held_value, rsp_value_changed,
//           |           |                     | rsp_axis_invalid
//   csr     | in        | csr_wr_en           | csr_index, csr_wdata
//
// A new word is accepted only in idle, after the previous word is done: the row
// read of the window memory, the pairwise compare, the rank select and the write-back follow in turn.
// Write-back waits while a previous result is still stalled on rsp.
// Synchronous active-high reset clears control, fill counts and configuration registers;
// window memory contents are not cleared, no clearing pass is needed.
// ----------------------------------------------------------------------------
module axis_median_deadband_filter_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [amdf_pkg::AXIS_W-1:0]   req_axis_index,
   input  logic [amdf_pkg::SAMPLE_W-1:0] req_sample_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [amdf_pkg::SAMPLE_W-1:0] rsp_held_value,
   output logic                          rsp_value_changed,
   output logic                          rsp_axis_invalid,
   input  logic                          csr_wr_en,
   input  logic [amdf_pkg::CSR_IW-1:0]   csr_index,
   input  logic [amdf_pkg::CSR_DW-1:0]   csr_wdata
);

   localparam int W  = amdf_pkg::WINDOW;
   localparam int SW = amdf_pkg::SAMPLE_W;

   amdf_pkg::state_type state_ff, state_in;

   logic [amdf_pkg::MARGIN_W-1:0] margin_ff;
   logic [amdf_pkg::ACTIVE_W-1:0] active_ff;

   logic [amdf_pkg::ROW_W-1:0]    win_mem [amdf_pkg::NUM_AXES];
   logic [amdf_pkg::ROW_W-1:0]    rd_row_ff;
   logic [amdf_pkg::CNT_W-1:0]    count_ff [amdf_pkg::NUM_AXES];

   logic [amdf_pkg::ADDR_W-1:0]   addr_ff;
   logic [SW-1:0]                 sample_ff;
   logic                          invalid_ff;

   logic [W-1:0][W-1:0]           lt_ff, lt_in;
   logic [SW-1:0]                 med_ff, med_in;
   logic                          med_ok_ff, med_ok_in;
   logic [W-1:0]                  med_sel;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0]                 rsp_held_value_ff;
   logic                          rsp_value_changed_ff;
   logic                          rsp_axis_invalid_ff;

   logic                          accept;
   logic                          wb_fire;
   logic                          axis_bad;
   logic [amdf_pkg::ADDR_W-1:0]   req_addr;
   logic [amdf_pkg::CNT_W-1:0]    fill_n;
   logic [SW-1:0]                 slot_val [W];
   logic [W-1:0]                  slot_full;
   logic [SW:0]                   lo_sum, hi_sum;
   logic                          do_write;
   logic [SW-1:0]                 new_held;
   logic [amdf_pkg::ROW_W-1:0]    new_row;

   assign accept   = req_valid && !req_stall;
   assign req_addr = amdf_pkg::ADDR_W'(req_axis_index);
   assign axis_bad = ({1'b0, req_axis_index} >= active_ff)
                     || (int'(req_axis_index) >= amdf_pkg::NUM_AXES);
   assign fill_n   = count_ff[addr_ff];

   // ---------------------------------------------------------------------
   // Control
   // ---------------------------------------------------------------------
   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      wb_fire   = 1'b0;
      unique case (state_ff)
         amdf_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               state_in = amdf_pkg::ST_CMP;
            end
         end
         amdf_pkg::ST_CMP: state_in = amdf_pkg::ST_MED;
         amdf_pkg::ST_MED: state_in = amdf_pkg::ST_WB;
         amdf_pkg::ST_WB: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               wb_fire  = 1'b1;
               state_in = amdf_pkg::ST_IDLE;
            end
         end
         default: state_in = amdf_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= amdf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff <= amdf_pkg::NOISE_MARGIN_RST;
         active_ff <= amdf_pkg::ACTIVE_AXES_RST;
      end else if (csr_wr_en) begin
         if (csr_index == amdf_pkg::CSR_NOISE_MARGIN) begin
            margin_ff <= csr_wdata[amdf_pkg::MARGIN_W-1:0];
         end else if (csr_index == amdf_pkg::CSR_ACTIVE_AXES) begin
            active_ff <= csr_wdata[amdf_pkg::ACTIVE_W-1:0];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Window memory: row read on accept, row write on write-back
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_row_ff <= win_mem[req_addr];
      end
      if (wb_fire && !invalid_ff) begin
         win_mem[addr_ff] <= new_row;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         addr_ff    <= req_addr;
         sample_ff  <= req_sample_value;
         invalid_ff <= axis_bad;
      end
   end

   // slot h is filled iff h < fill count, since samples enter at slot 0
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < amdf_pkg::NUM_AXES; a++) begin
            count_ff[a] <= '0;
         end
      end else if (wb_fire && !invalid_ff && (int'(fill_n) < W)) begin
         count_ff[addr_ff] <= fill_n + amdf_pkg::CNT_W'(1);
      end
   end

   // ---------------------------------------------------------------------
   // Pairwise compare: lt[i][j] set when slot j orders before slot i.
   // Empty slots order lowest; ties break on slot number.
   // ---------------------------------------------------------------------
   always_comb begin
      for (int h = 0; h < W; h++) begin
         slot_full[h] = (h < int'(fill_n));
         slot_val[h]  = slot_full[h] ? rd_row_ff[h*SW +: SW] : '0;
      end
      for (int i = 0; i < W; i++) begin
         for (int j = 0; j < W; j++) begin
            if (slot_full[i] != slot_full[j]) begin
               lt_in[i][j] = slot_full[i];
            end else if (slot_val[i] != slot_val[j]) begin
               lt_in[i][j] = (slot_val[j] < slot_val[i]);
            end else begin
               lt_in[i][j] = (j < i);
            end
         end
      end
   end

   // rank each slot and pick the middle one
   always_comb begin
      logic [amdf_pkg::RANK_W-1:0] rank;
      med_in    = '0;
      med_ok_in = 1'b0;
      for (int i = 0; i < W; i++) begin
         rank = '0;
         for (int j = 0; j < W; j++) begin
            rank = rank + amdf_pkg::RANK_W'(lt_ff[i][j]);
         end
         med_sel[i] = (int'(rank) == amdf_pkg::MED_RANK);
         if (med_sel[i]) begin
            med_in    = slot_val[i];
            med_ok_in = slot_full[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == amdf_pkg::ST_CMP) begin
         lt_ff <= lt_in;
      end
      if (state_ff == amdf_pkg::ST_MED) begin
         med_ff    <= med_in;
         med_ok_ff <= med_ok_in;
      end
   end

   // ---------------------------------------------------------------------
   // Deadband decision and row update
   // ---------------------------------------------------------------------
   always_comb begin
      lo_sum   = {1'b0, sample_ff} + (SW+1)'(margin_ff);
      hi_sum   = {1'b0, med_ff} + (SW+1)'(margin_ff);
      do_write = !med_ok_ff || (lo_sum < {1'b0, med_ff})
                 || ({1'b0, sample_ff} > hi_sum);
      new_held = do_write ? sample_ff : rd_row_ff[W*SW +: SW];
      new_row  = {new_held, rd_row_ff[(W-1)*SW-1:0], sample_ff};
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (wb_fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wb_fire) begin
         rsp_held_value_ff    <= invalid_ff ? '0 : new_held;
         rsp_value_changed_ff <= !invalid_ff && do_write;
         rsp_axis_invalid_ff  <= invalid_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_held_value    = rsp_held_value_ff;
   assign rsp_value_changed = rsp_value_changed_ff;
   assign rsp_axis_invalid  = rsp_axis_invalid_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_rsp_from_wb: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == amdf_pkg::ST_WB))
      else $error("result word raised outside write-back");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == amdf_pkg::ST_CMP))
      else $error("accepted word did not start compare");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      int'(fill_n) <= W)
      else $error("fill count above window depth");

   a_median_unique: assert property (@(posedge clock) disable iff (reset)
      (state_ff == amdf_pkg::ST_MED) |-> $onehot(med_sel))
      else $error("median rank not unique");

   a_invalid_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_axis_invalid_ff)
         |-> (!rsp_value_changed_ff && (rsp_held_value_ff == '0)))
      else $error("rejected axis word carries data");

endmodule
